/* rtl/chbb_pkg.sv */
// shared types and constants for the color histogram box builder
package chbb_pkg;

	localparam int CHANNEL_BITS_DEF = 5;
	localparam int COUNT_BITS_DEF = 24;
	localparam int QUEUE_DEPTH = 4;

	localparam int BOUND_BITS = 5;
	localparam int BIN_COUNT_BITS = 24;
	localparam int IN_DATA_BITS = 48;
	localparam int OUT_DATA_BITS = 56;

	localparam logic [7:0] ALPHA_MIN = 8'd125;
	localparam logic [7:0] WHITE_LEVEL = 8'd250;
	localparam logic [7:0] STRIDE_RESET = 8'd10;

	localparam logic [1:0] MODE_PIXEL = 2'd0;
	localparam logic [1:0] MODE_BIN = 2'd1;
	localparam logic [1:0] MODE_BOX = 2'd2;

	localparam logic REG_STRIDE = 1'b0;
	localparam logic REG_IGNORE_WHITE = 1'b1;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_INC,
		OP_READ,
		OP_BOX
	} op_t;

	// packed from the top down, so valid lands in the lowest bit
	typedef struct packed {
		logic [BOUND_BITS-1:0] blue_high;
		logic [BOUND_BITS-1:0] blue_low;
		logic [BOUND_BITS-1:0] green_high;
		logic [BOUND_BITS-1:0] green_low;
		logic [BOUND_BITS-1:0] red_high;
		logic [BOUND_BITS-1:0] red_low;
		logic valid;
	} box_t;

	localparam int OP_BITS = $bits(op_t);
	localparam int BOX_BITS = $bits(box_t);

endpackage

/* rtl/chbb_fifo.sv */
// small register queue between the front and the back
module chbb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);
	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign full = (count_q == CNT_BITS'(DEPTH));
	assign empty = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/chbb_front.sv */
// front end: sampling, drop tests, bin index and bounding box tracking
module chbb_front
	import chbb_pkg::*;
#(
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
	parameter int HIST_BITS = 3 * CHANNEL_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           mode,
	input  logic [7:0]           red,
	input  logic [7:0]           green,
	input  logic [7:0]           blue,
	input  logic [7:0]           alpha,
	input  logic [14:0]          bin_index,
	input  logic                 clear_busy,
	input  logic                 queue_full,
	output logic                 push,
	output op_t                  push_op,
	output logic [HIST_BITS-1:0] push_addr,
	output box_t                 push_box
);
	logic [7:0] stride_q;
	logic ignore_white_q;
	logic [7:0] phase_q;
	logic any_q;
	logic [CHANNEL_BITS-1:0] red_min_q, red_max_q;
	logic [CHANNEL_BITS-1:0] green_min_q, green_max_q;
	logic [CHANNEL_BITS-1:0] blue_min_q, blue_max_q;

	logic [7:0] stride_eff;
	logic [8:0] phase_inc;
	logic [7:0] phase_next;
	logic sampled, opaque, white, keep;
	logic [CHANNEL_BITS-1:0] rr, gg, bb;

	assign in_ready = !clear_busy && !queue_full;
	assign push = in_valid && in_ready;

	assign stride_eff = (stride_q == '0) ? 8'd1 : stride_q;
	assign phase_inc = {1'b0, phase_q} + 9'd1;
	// a phase at or past a lowered stride wraps here too
	assign phase_next = (phase_inc >= {1'b0, stride_eff}) ? 8'd0 : phase_inc[7:0];
	assign sampled = (phase_q == '0);
	assign opaque = (alpha > ALPHA_MIN);
	assign white = ignore_white_q && (red > WHITE_LEVEL) && (green > WHITE_LEVEL)
		&& (blue > WHITE_LEVEL);
	assign keep = sampled && opaque && !white;

	assign rr = red[7 -: CHANNEL_BITS];
	assign gg = green[7 -: CHANNEL_BITS];
	assign bb = blue[7 -: CHANNEL_BITS];

	always_comb begin
		push_op = OP_NONE;
		push_addr = HIST_BITS'({rr, gg, bb});
		unique case (mode)
			MODE_PIXEL: push_op = keep ? OP_INC : OP_NONE;
			MODE_BIN: begin
				push_op = OP_READ;
				push_addr = HIST_BITS'(bin_index);
			end
			MODE_BOX: push_op = OP_BOX;
			default: push_op = OP_NONE;
		endcase
	end

	always_comb begin
		push_box.valid = any_q;
		push_box.red_low = BOUND_BITS'(red_min_q);
		push_box.red_high = BOUND_BITS'(red_max_q);
		push_box.green_low = BOUND_BITS'(green_min_q);
		push_box.green_high = BOUND_BITS'(green_max_q);
		push_box.blue_low = BOUND_BITS'(blue_min_q);
		push_box.blue_high = BOUND_BITS'(blue_max_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= STRIDE_RESET;
			ignore_white_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_STRIDE) begin
				stride_q <= cfg_data;
			end else if (cfg_index == REG_IGNORE_WHITE) begin
				ignore_white_q <= cfg_data[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			any_q <= 1'b0;
			red_min_q <= '1;
			green_min_q <= '1;
			blue_min_q <= '1;
			red_max_q <= '0;
			green_max_q <= '0;
			blue_max_q <= '0;
		end else if (push) begin
			if (mode == MODE_PIXEL) begin
				phase_q <= phase_next;
				if (keep) begin
					any_q <= 1'b1;
					if (rr < red_min_q) red_min_q <= rr;
					if (rr > red_max_q) red_max_q <= rr;
					if (gg < green_min_q) green_min_q <= gg;
					if (gg > green_max_q) green_max_q <= gg;
					if (bb < blue_min_q) blue_min_q <= bb;
					if (bb > blue_max_q) blue_max_q <= bb;
				end
			end else if (mode == MODE_BOX) begin
				phase_q <= '0;
				any_q <= 1'b0;
				red_min_q <= '1;
				green_min_q <= '1;
				blue_min_q <= '1;
				red_max_q <= '0;
				green_max_q <= '0;
				blue_max_q <= '0;
			end
		end
	end

endmodule

/* rtl/chbb_back.sv */
// back end: histogram memory read-modify-write, clearing pass and result register
module chbb_back
	import chbb_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	parameter int HIST_BITS = 15
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_empty,
	output logic                     q_pop,
	input  op_t                      q_op,
	input  logic [HIST_BITS-1:0]     q_addr,
	input  box_t                     q_box,
	output logic                     clear_busy,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [OUT_DATA_BITS-1:0] out_data
);
	localparam int HIST_DEPTH = 1 << HIST_BITS;

	logic [COUNT_BITS-1:0] mem [HIST_DEPTH];

	logic clr_busy_q;
	logic [HIST_BITS-1:0] clr_addr_q;

	logic v_s2;
	op_t op_s2;
	logic [HIST_BITS-1:0] addr_s2;
	box_t box_s2;
	logic [COUNT_BITS-1:0] rdata_s2;

	logic lw_valid_q;
	logic [HIST_BITS-1:0] lw_addr_q;
	logic [COUNT_BITS-1:0] lw_data_q;

	logic out_valid_q;
	logic [OUT_DATA_BITS-1:0] out_data_q;

	logic advance;
	logic [COUNT_BITS-1:0] cur, upd;
	logic wr_en;
	logic [HIST_BITS-1:0] wr_addr;
	logic [COUNT_BITS-1:0] wr_data;
	logic [BIN_COUNT_BITS-1:0] count_out;
	box_t box_out;

	assign clear_busy = clr_busy_q;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	assign advance = !out_valid_q || out_ready;
	assign q_pop = advance && !q_empty && !clr_busy_q;

	// the write from the op just ahead lands on the same edge as this op's read
	assign cur = (lw_valid_q && lw_addr_q == addr_s2) ? lw_data_q : rdata_s2;

	always_comb begin
		upd = '0;
		wr_en = 1'b0;
		count_out = '0;
		box_out = '0;
		case (op_s2)
			OP_INC: begin
				upd = (cur == {COUNT_BITS{1'b1}}) ? cur : cur + 1'b1;
				wr_en = v_s2 && advance;
			end
			OP_READ: begin
				upd = '0;
				wr_en = v_s2 && advance;
				count_out = BIN_COUNT_BITS'(cur);
			end
			OP_BOX: box_out = box_s2;
			default: upd = '0;
		endcase
	end

	assign wr_addr = clr_busy_q ? clr_addr_q : addr_s2;
	assign wr_data = clr_busy_q ? '0 : upd;

	always_ff @(posedge clk) begin
		if (clr_busy_q || wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (advance) begin
			rdata_s2 <= mem[q_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_s2 <= q_op;
			addr_s2 <= q_addr;
			box_s2 <= q_box;
		end
		if (wr_en) begin
			lw_addr_q <= addr_s2;
			lw_data_q <= upd;
		end
		if (advance) begin
			out_data_q <= {box_out, count_out, op_s2 == OP_INC};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			v_s2 <= 1'b0;
			lw_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == {HIST_BITS{1'b1}}) begin
					clr_busy_q <= 1'b0;
				end
				lw_valid_q <= 1'b0;
			end else if (wr_en) begin
				lw_valid_q <= 1'b1;
			end
			if (advance) begin
				v_s2 <= q_pop;
				out_valid_q <= v_s2;
			end
		end
	end

endmodule

/* rtl/color_histogram_box_builder_top.sv */
// top level of the color histogram and bounding box builder
// Takes one item per clock cycle while s_tready is high (pixel, bin read-and-clear,
// or box read-and-reset) and returns exactly one result per item, in order. The
// rate is set by the histogram memory's single read-modify-write port, pipelined
// over a read stage and a write stage with forwarding so that repeated hits on one
// bin still go at one per cycle; a four-entry queue separates input from output
// stalls. After reset the histogram memory is cleared one bin a cycle, all
// 2^(3*CHANNEL_BITS) bins (32768 by default), and s_tready stays low until that
// pass is done; configuration writes are taken at any time the block is idle.
module color_histogram_box_builder_top
	import chbb_pkg::*;
#(
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [7:0]               cfg_data,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// red, green, blue, alpha, bin_index, zero pad
	input  logic [IN_DATA_BITS-1:0]  s_tdata,
	// mode
	input  logic [1:0]               s_tuser,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// accepted, bin_count, box_valid, red_low, red_high, green_low, green_high,
	// blue_low, blue_high
	output logic [OUT_DATA_BITS-1:0] m_tdata
);
	localparam int HIST_BITS = 3 * CHANNEL_BITS;
	localparam int Q_BITS = OP_BITS + HIST_BITS + BOX_BITS;

	logic clear_busy, queue_full, queue_empty, push, pop;
	op_t push_op;
	logic [HIST_BITS-1:0] push_addr;
	box_t push_box;
	logic [Q_BITS-1:0] pop_data;
	op_t pop_op;
	logic [HIST_BITS-1:0] pop_addr;
	box_t pop_box;

	chbb_front #(
		.CHANNEL_BITS(CHANNEL_BITS),
		.HIST_BITS(HIST_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.mode(s_tuser),
		.red(s_tdata[7:0]),
		.green(s_tdata[15:8]),
		.blue(s_tdata[23:16]),
		.alpha(s_tdata[31:24]),
		.bin_index(s_tdata[46:32]),
		.clear_busy(clear_busy),
		.queue_full(queue_full),
		.push(push),
		.push_op(push_op),
		.push_addr(push_addr),
		.push_box(push_box)
	);

	chbb_fifo #(
		.WIDTH(Q_BITS),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data({push_op, push_addr, push_box}),
		.full(queue_full),
		.pop(pop),
		.pop_data(pop_data),
		.empty(queue_empty)
	);

	assign pop_op = op_t'(pop_data[Q_BITS-1 -: OP_BITS]);
	assign pop_addr = pop_data[BOX_BITS +: HIST_BITS];
	assign pop_box = pop_data[BOX_BITS-1:0];

	chbb_back #(
		.COUNT_BITS(COUNT_BITS),
		.HIST_BITS(HIST_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(queue_empty),
		.q_pop(pop),
		.q_op(pop_op),
		.q_addr(pop_addr),
		.q_box(pop_box),
		.clear_busy(clear_busy),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data(m_tdata)
	);

endmodule

/* test/testbench.sv */
// self-checking testbench for the color histogram box builder, directed and random stream traffic
module testbench;
	import chbb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 180;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [14:0] bin_index;
	} item_t;

	typedef struct packed {
		logic        accepted;
		logic [23:0] bin_count;
		logic        box_valid;
		logic [4:0]  red_low;
		logic [4:0]  red_high;
		logic [4:0]  green_low;
		logic [4:0]  green_high;
		logic [4:0]  blue_low;
		logic [4:0]  blue_high;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [7:0] cfg_data = 8'd0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_BITS-1:0] s_tdata = '0;
	logic [1:0] s_tuser = MODE_PIXEL;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_tdata;

	color_histogram_box_builder_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	// predictor state
	bit [23:0] hist_counts [0:32767];
	bit [4:0] red_min, red_max, green_min, green_max, blue_min, blue_max;
	bit box_seen;
	int stride_pos;
	bit [7:0] stride_cfg = STRIDE_RESET;
	bit white_skip = 1'b0;

	item_t items_to_send [$];
	result_t expected_results [$];
	item_t on_bus;

	int send_gap, recv_gap;
	bit send_idle_on, recv_idle_on;
	bit hold_arm = 1'b0;
	int hold_cnt;
	logic hold_on;
	int mismatches, fail_count, cycles;

	bit [23:0] palette [0:7];

	function automatic void clear_box();
		red_min = 5'd31;
		green_min = 5'd31;
		blue_min = 5'd31;
		red_max = 5'd0;
		green_max = 5'd0;
		blue_max = 5'd0;
		box_seen = 1'b0;
		stride_pos = 0;
	endfunction

	initial clear_box();

	function automatic result_t bin_and_box_update(item_t it);
		result_t res;
		int span;
		bit took;
		bit [4:0] rr, gg, bb;
		bit [14:0] bin;
		res = '0;
		case (it.mode)
			MODE_PIXEL: begin
				span = (stride_cfg == 0) ? 1 : stride_cfg;
				took = (stride_pos == 0);
				stride_pos = (stride_pos + 1 >= span) ? 0 : stride_pos + 1;
				if (took && it.alpha > ALPHA_MIN && !(white_skip && it.red > WHITE_LEVEL
						&& it.green > WHITE_LEVEL && it.blue > WHITE_LEVEL)) begin
					rr = it.red[7:3];
					gg = it.green[7:3];
					bb = it.blue[7:3];
					bin = {rr, gg, bb};
					if (rr < red_min) red_min = rr;
					if (rr > red_max) red_max = rr;
					if (gg < green_min) green_min = gg;
					if (gg > green_max) green_max = gg;
					if (bb < blue_min) blue_min = bb;
					if (bb > blue_max) blue_max = bb;
					box_seen = 1'b1;
					if (hist_counts[bin] != 24'hFFFFFF) hist_counts[bin]++;
					res.accepted = 1'b1;
				end
			end
			MODE_BIN: begin
				res.bin_count = hist_counts[it.bin_index];
				hist_counts[it.bin_index] = '0;
			end
			MODE_BOX: begin
				res.box_valid = box_seen;
				res.red_low = red_min;
				res.red_high = red_max;
				res.green_low = green_min;
				res.green_high = green_max;
				res.blue_low = blue_min;
				res.blue_high = blue_max;
				clear_box();
			end
			default: ;
		endcase
		return res;
	endfunction

	// input side
	always @(posedge clk or negedge arst_n) begin : drive_items
		logic go;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap <= 0;
		end else begin
			go = 1'b0;
			if (s_tvalid && s_tready)
				expected_results = {expected_results, bin_and_box_update(on_bus)};
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
				end else if (items_to_send.size() > 0) begin
					if (send_idle_on && $urandom_range(0, 7) == 0) begin
						send_gap <= $urandom_range(0, 13);
					end else begin
						on_bus = items_to_send.pop_front();
						s_tdata <= {1'b0, on_bus.bin_index, on_bus.alpha, on_bus.blue,
							on_bus.green, on_bus.red};
						s_tuser <= on_bus.mode;
						go = 1'b1;
					end
				end
				s_tvalid <= go;
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (!hold_arm)
			hold_cnt <= 0;
		else if (hold_cnt < HOLD_CYCLES)
			hold_cnt <= hold_cnt + 1;
	end

	assign hold_on = hold_arm && (hold_cnt < HOLD_CYCLES);

	// output side
	always @(posedge clk or negedge arst_n) begin : watch_results
		result_t got;
		result_t want;
		logic rdy;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.accepted = m_tdata[0];
				got.bin_count = m_tdata[24:1];
				got.box_valid = m_tdata[25];
				got.red_low = m_tdata[30:26];
				got.red_high = m_tdata[35:31];
				got.green_low = m_tdata[40:36];
				got.green_high = m_tdata[45:41];
				got.blue_low = m_tdata[50:46];
				got.blue_high = m_tdata[55:51];
				if (expected_results.size() == 0) begin
					fail_count++;
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result transfer with nothing expected: %h", $realtime,
							m_tdata);
				end else begin
					want = expected_results.pop_front();
					if (want.accepted !== got.accepted || want.bin_count !== got.bin_count
							|| want.box_valid !== got.box_valid
							|| want.red_low !== got.red_low || want.red_high !== got.red_high
							|| want.green_low !== got.green_low
							|| want.green_high !== got.green_high
							|| want.blue_low !== got.blue_low
							|| want.blue_high !== got.blue_high) begin
						fail_count++;
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: mismatch exp %b %0d %b %0d %0d %0d %0d %0d %0d",
								$realtime, want.accepted, want.bin_count, want.box_valid,
								want.red_low, want.red_high, want.green_low, want.green_high,
								want.blue_low, want.blue_high);
							$display("    got %b %0d %b %0d %0d %0d %0d %0d %0d",
								got.accepted, got.bin_count, got.box_valid, got.red_low,
								got.red_high, got.green_low, got.green_high, got.blue_low,
								got.blue_high);
						end
					end
				end
			end
			rdy = 1'b1;
			if (hold_on) begin
				rdy = 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				rdy = 1'b0;
			end else if (recv_idle_on && $urandom_range(0, 7) == 0) begin
				recv_gap <= $urandom_range(0, 13);
				rdy = 1'b0;
			end
			m_tready <= rdy;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	task automatic write_reg(input logic idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_STRIDE)
			stride_cfg = val;
		else
			white_skip = val[0];
	endtask

	// checked away from the rising edge so the driver's updates have settled
	task automatic wait_idle();
		@(negedge clk);
		while (items_to_send.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (12) @(posedge clk);
	endtask

	function automatic void add_pixel(input logic [7:0] r, g, b, a);
		item_t it;
		it = '0;
		it.mode = MODE_PIXEL;
		it.red = r;
		it.green = g;
		it.blue = b;
		it.alpha = a;
		it.bin_index = 15'($urandom);
		items_to_send = {items_to_send, it};
	endfunction

	function automatic void add_query(input logic [1:0] mode, input logic [14:0] bin);
		item_t it;
		it = '0;
		it.mode = mode;
		it.bin_index = bin;
		it.red = 8'($urandom);
		it.alpha = 8'($urandom);
		items_to_send = {items_to_send, it};
	endfunction

	// mostly palette colors so bins collide and bin reads find counts
	function automatic void add_random_items(input int n);
		int p;
		bit [23:0] c;
		logic [7:0] r, g, b, a;
		for (int i = 0; i < 8; i++)
			palette[i] = 24'($urandom);
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(0, 99);
			c = palette[3'($urandom_range(0, 7))];
			if (p < 72) begin
				if ($urandom_range(0, 9) < 7) begin
					r = {c[23:19], 3'($urandom)};
					g = {c[15:11], 3'($urandom)};
					b = {c[7:3], 3'($urandom)};
				end else if ($urandom_range(0, 2) == 0) begin
					r = 8'($urandom_range(248, 255));
					g = 8'($urandom_range(248, 255));
					b = 8'($urandom_range(248, 255));
				end else begin
					r = 8'($urandom);
					g = 8'($urandom);
					b = 8'($urandom);
				end
				a = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(126, 255))
					: 8'($urandom_range(0, 125));
				add_pixel(r, g, b, a);
			end else if (p < 91) begin
				if ($urandom_range(0, 2) != 0)
					add_query(MODE_BIN, {c[23:19], c[15:11], c[7:3]});
				else
					add_query(MODE_BIN, 15'($urandom));
			end else if (p < 98) begin
				add_query(MODE_BOX, 15'($urandom));
			end else begin
				add_query(MODE_UNUSED, 15'($urandom));
			end
		end
	endfunction

	initial begin : run_test
		bit [7:0] strides [0:6];
		bit whites [0:6];
		strides = '{8'd1, 8'd2, 8'd255, 8'd1, 8'd7, 8'd3, 8'd1};
		whites = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
		send_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: drop tests, bin reads, box reads, unused mode
		write_reg(REG_STRIDE, 8'd1);
		write_reg(REG_IGNORE_WHITE, 8'd1);
		add_query(MODE_BOX, 15'd0);
		add_pixel(8'd0, 8'd0, 8'd0, 8'd125);
		add_pixel(8'd0, 8'd0, 8'd0, 8'd126);
		add_pixel(8'd255, 8'd255, 8'd255, 8'd255);
		add_pixel(8'd251, 8'd251, 8'd250, 8'd255);
		add_pixel(8'd8, 8'd16, 8'd24, 8'd200);
		add_query(MODE_BIN, 15'h7FFF);
		add_query(MODE_BIN, 15'd0);
		add_query(MODE_BIN, 15'd0);
		add_query(MODE_UNUSED, 15'h7FFF);
		add_query(MODE_BOX, 15'd0);
		add_query(MODE_BOX, 15'd0);
		wait_idle();
		write_reg(REG_STRIDE, 8'd5);
		for (int i = 0; i < 3; i++) add_pixel(8'd40, 8'd80, 8'd120, 8'd255);
		wait_idle();
		// stride lowered below the current phase
		write_reg(REG_STRIDE, 8'd2);
		for (int i = 0; i < 3; i++) add_pixel(8'd200, 8'd100, 8'd50, 8'd255);
		add_query(MODE_BOX, 15'd0);
		wait_idle();
		// zero stride samples every pixel
		write_reg(REG_STRIDE, 8'd0);
		for (int i = 0; i < 3; i++) add_pixel(8'd255, 8'd0, 8'd128, 8'd255);
		wait_idle();
		write_reg(REG_IGNORE_WHITE, 8'd0);
		for (int i = 0; i < 4; i++) add_pixel(8'd255, 8'd255, 8'd255, 8'd255);
		add_query(MODE_BIN, 15'h7FFF);
		add_query(MODE_BOX, 15'd0);
		wait_idle();

		for (int ph = 0; ph < 7; ph++) begin
			write_reg(REG_STRIDE, strides[ph]);
			write_reg(REG_IGNORE_WHITE, {7'd0, whites[ph]});
			send_idle_on = (ph < 6) && ($urandom_range(0, 3) != 0);
			recv_idle_on = (ph < 6) && ($urandom_range(0, 3) != 0);
			hold_arm = (ph == 1);
			add_random_items(PHASE_ITEMS);
			wait_idle();
			hold_arm = 1'b0;
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

/* color_histogram_box_builder_top.f */
rtl/chbb_pkg.sv
rtl/chbb_fifo.sv
rtl/chbb_front.sv
rtl/chbb_back.sv
rtl/color_histogram_box_builder_top.sv
test/testbench.sv
